// ===== sv/dde_pkg.sv =====
// ----------------------------------------------------------------------------
// dde_pkg - shared types and constants of the deadlock detection engine
// command codes, chain token format and load strobes used by the engine, cell and sequencer
// ----------------------------------------------------------------------------
package dde_pkg;

  // default sizes of the engine
  localparam int MAX_PROCS_DEF = 16;
  localparam int MAX_RES_DEF   = 16;

  // fixed field widths
  localparam int VALUE_W = 8;
  localparam int CMD_W   = 2;
  localparam int IDX_IN_W = 4;
  localparam int CNT_IN_W = 5;
  localparam int MASK_W  = 16;
  localparam int MASK_IW = 4;
  localparam int OUT_CNT_W = 5;
  // wide enough to hold any index or count up to the largest size (64)
  localparam int IDX_EXT_W = 7;

  // configuration register indexes
  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_TOTAL  = 2'd0,
    CMD_LOAD_REQ   = 2'd1,
    CMD_LOAD_ALLOC = 2'd2,
    CMD_RUN        = 2'd3
  } cmd_t;

  // operation carried by a token along the cell chain
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CHECK = 2'd1,
    OP_ADD   = 2'd2
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic flag;
  } tok_t;

  // per-cell load strobes
  typedef struct packed {
    logic tot_we;
    logic req_we;
    logic alloc_we;
  } ld_t;

endpackage

// ===== sv/deadlock_detection_engine.sv =====
// ----------------------------------------------------------------------------
// deadlock_detection_engine - deadlock detection over a resource chain
// loads totals, request and allocation matrices, then runs detection
// ----------------------------------------------------------------------------
// Load items (set total, load request, load allocation) are taken one per
// cycle while no run holds the input channel, and give no result. A run
// item makes one result: the deadlock flag, the mask of unfinished
// processes (processes 0 to 15) and their count. The engine is a chain of
// MAX_RES resource cells; each cell holds the total, the work value and the
// request/allocation column of one resource in two small rams, and a token
// passes through stage a and then the output register of each cell. A run
// first forms work and the initial finished flags, then checks every
// unfinished process in passes (finished processes are skipped), starting
// another pass while any process finished in the last one, and at the end
// drains the chain and counts the unfinished processes. The input channel
// stalls for the whole run and opens again once the result sits in the
// output register. Reset needs no clearing pass: stores are undefined until
// written.
// ----------------------------------------------------------------------------
module deadlock_detection_engine #(
  parameter int MAX_PROCS = dde_pkg::MAX_PROCS_DEF,
  parameter int MAX_RES   = dde_pkg::MAX_RES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [dde_pkg::CNT_IN_W-1:0]   cfg_wdata,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dde_pkg::CMD_W-1:0]      in_command,
  input  logic [dde_pkg::IDX_IN_W-1:0]   in_process_index,
  input  logic [dde_pkg::IDX_IN_W-1:0]   in_resource_index,
  input  logic [dde_pkg::VALUE_W-1:0]    in_value,
  // result item channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_deadlock,
  output logic [dde_pkg::MASK_W-1:0]     out_unfinished_mask,
  output logic [dde_pkg::OUT_CNT_W-1:0]  out_unfinished_count
);

  localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int RCW = $clog2(MAX_RES + 1);
  localparam int XW  = dde_pkg::IDX_EXT_W;

  // configuration registers
  logic [dde_pkg::CNT_IN_W-1:0] pc_r, rc_r;
  logic [XW-1:0]                pc_ext, rc_ext;
  logic [CW-1:0]                np;
  logic [RCW-1:0]               nr;

  // input decode
  logic                         acc, run_go, busy;
  logic [XW-1:0]                proc_ext, res_ext;
  logic                         proc_ok, res_ok;
  logic [PW-1:0]                ld_addr;

  // cell chain links
  dde_pkg::tok_t                tok_w [MAX_RES+1];
  logic [PW-1:0]                p_w   [MAX_RES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dde_pkg::CNT_IN_W'(16);
      rc_r <= dde_pkg::CNT_IN_W'(16);
    end else if (cfg_we) begin
      if (cfg_index == dde_pkg::REG_PROCESS_COUNT) begin
        pc_r <= cfg_wdata;
      end
      if (cfg_index == dde_pkg::REG_RESOURCE_COUNT) begin
        rc_r <= cfg_wdata;
      end
    end
  end

  // counts above the chain size saturate
  assign pc_ext = XW'(pc_r);
  assign rc_ext = XW'(rc_r);
  assign np = (pc_ext > XW'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(pc_ext);
  assign nr = (rc_ext > XW'(MAX_RES)) ? RCW'(MAX_RES) : RCW'(rc_ext);

  // run holds the input side until its result is registered
  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;
  assign run_go   = acc && (in_command == dde_pkg::CMD_RUN);

  // loads outside the chain sizes (MAX_PROCS, MAX_RES) are dropped
  assign proc_ext = XW'(in_process_index);
  assign res_ext  = XW'(in_resource_index);
  assign proc_ok  = proc_ext < XW'(MAX_PROCS);
  assign res_ok   = res_ext < XW'(MAX_RES);
  assign ld_addr  = proc_ext[PW-1:0];

  for (genvar i = 0; i < MAX_RES; i++) begin : g_cell
    dde_pkg::ld_t ld;
    logic         sel;

    assign sel = acc && res_ok && (res_ext == XW'(i));
    assign ld.tot_we   = sel && (in_command == dde_pkg::CMD_SET_TOTAL);
    assign ld.req_we   = sel && proc_ok && (in_command == dde_pkg::CMD_LOAD_REQ);
    assign ld.alloc_we = sel && proc_ok && (in_command == dde_pkg::CMD_LOAD_ALLOC);

    dde_cell #(
      .IDX       (i),
      .MAX_PROCS (MAX_PROCS),
      .MAX_RES   (MAX_RES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (run_go),
      .ld       (ld),
      .ld_addr  (ld_addr),
      .ld_value (in_value),
      .nr       (nr),
      .tok_i    (tok_w[i]),
      .p_i      (p_w[i]),
      .tok_o    (tok_w[i+1]),
      .p_o      (p_w[i+1])
    );
  end

  // sequencer feeds the head of the chain and watches its tail
  dde_ctrl #(
    .MAX_PROCS (MAX_PROCS),
    .MAX_RES   (MAX_RES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .run_go       (run_go),
    .np           (np),
    .exit_tok     (tok_w[MAX_RES]),
    .exit_p       (p_w[MAX_RES]),
    .inj_tok      (tok_w[0]),
    .inj_p        (p_w[0]),
    .busy         (busy),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_deadlock (out_deadlock),
    .out_mask     (out_unfinished_mask),
    .out_count    (out_unfinished_count)
  );

endmodule

// ===== sv/dde_ram.sv =====
// ----------------------------------------------------------------------------
// dde_ram - generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dde_cell.sv =====
// ----------------------------------------------------------------------------
// dde_cell - one resource column of the detection chain
// holds total, work and the request/allocation column of one resource type
// ----------------------------------------------------------------------------
module dde_cell #(
  parameter int IDX       = 0,
  parameter int MAX_PROCS = dde_pkg::MAX_PROCS_DEF,
  parameter int MAX_RES   = dde_pkg::MAX_RES_DEF,
  localparam int PW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int RCW      = $clog2(MAX_RES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  dde_pkg::ld_t                ld,
  input  logic [PW-1:0]               ld_addr,
  input  logic [dde_pkg::VALUE_W-1:0] ld_value,
  input  logic [RCW-1:0]              nr,
  input  dde_pkg::tok_t               tok_i,
  input  logic [PW-1:0]               p_i,
  output dde_pkg::tok_t               tok_o,
  output logic [PW-1:0]               p_o
);

  localparam int WORK_W = $clog2(MAX_PROCS) + 10;

  dde_pkg::tok_t              tok_a_r, tok_o_r, tok_nxt;
  logic [PW-1:0]              p_a_r, p_o_r;
  logic [dde_pkg::VALUE_W-1:0] total_r;
  logic signed [WORK_W-1:0]   work_r, work_nxt;
  logic [dde_pkg::VALUE_W-1:0] req_q, alloc_q;
  logic signed [WORK_W-1:0]   req_ext, alloc_ext;
  logic                       in_use;

  // read address follows the incoming token, data lines up with stage a
  dde_ram #(.WIDTH(dde_pkg::VALUE_W), .DEPTH(MAX_PROCS)) u_req_ram (
    .clk   (clk),
    .we    (ld.req_we),
    .waddr (ld_addr),
    .wdata (ld_value),
    .raddr (p_i),
    .rdata (req_q)
  );

  dde_ram #(.WIDTH(dde_pkg::VALUE_W), .DEPTH(MAX_PROCS)) u_alloc_ram (
    .clk   (clk),
    .we    (ld.alloc_we),
    .waddr (ld_addr),
    .wdata (ld_value),
    .raddr (p_i),
    .rdata (alloc_q)
  );

  assign req_ext   = WORK_W'(req_q);
  assign alloc_ext = WORK_W'(alloc_q);
  assign in_use    = RCW'(IDX) < nr;

  always_comb begin
    tok_nxt  = tok_a_r;
    work_nxt = work_r;
    if (start) begin
      work_nxt = WORK_W'(total_r);
    end else if (tok_a_r.valid && in_use) begin
      unique case (tok_a_r.op)
        dde_pkg::OP_INIT: begin
          work_nxt     = work_r - alloc_ext;
          tok_nxt.flag = tok_a_r.flag && (alloc_q == '0);
        end
        dde_pkg::OP_CHECK: begin
          tok_nxt.flag = tok_a_r.flag && (work_r >= req_ext);
        end
        dde_pkg::OP_ADD: begin
          work_nxt = work_r + alloc_ext;
        end
        default: begin
          tok_nxt = tok_a_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r.valid <= 1'b0;
      tok_o_r.valid <= 1'b0;
      work_r        <= '0;
    end else begin
      tok_a_r <= tok_i;
      tok_o_r <= tok_nxt;
      work_r  <= work_nxt;
    end
    p_a_r <= p_i;
    p_o_r <= p_a_r;
    if (ld.tot_we) begin
      total_r <= ld_value;
    end
  end

  assign tok_o = tok_o_r;
  assign p_o   = p_o_r;

endmodule

// ===== sv/dde_ctrl.sv =====
// ----------------------------------------------------------------------------
// dde_ctrl - run sequencer of the detection engine
// injects tokens into the cell chain, keeps finished flags, builds the result
// ----------------------------------------------------------------------------
module dde_ctrl #(
  parameter int MAX_PROCS = dde_pkg::MAX_PROCS_DEF,
  parameter int MAX_RES   = dde_pkg::MAX_RES_DEF,
  localparam int PW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int CW       = $clog2(MAX_PROCS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          run_go,
  input  logic [CW-1:0]                 np,
  input  dde_pkg::tok_t                 exit_tok,
  input  logic [PW-1:0]                 exit_p,
  output dde_pkg::tok_t                 inj_tok,
  output logic [PW-1:0]                 inj_p,
  output logic                          busy,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_deadlock,
  output logic [dde_pkg::MASK_W-1:0]    out_mask,
  output logic [dde_pkg::OUT_CNT_W-1:0] out_count
);

  localparam int DRAIN_LEN = 2 * MAX_RES;
  localparam int DW        = $clog2(DRAIN_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_INIT_WAIT, S_SCAN, S_WAIT, S_DRAIN, S_COUNT, S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   p_r, p_nxt;
  logic                            chg_r, chg_nxt;
  logic [MAX_PROCS-1:0]            fin_r, fin_nxt;
  logic [DW-1:0]                   drn_r, drn_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [dde_pkg::MASK_W-1:0]      mask_r, mask_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_deadlock_r, out_deadlock_nxt;
  logic [dde_pkg::MASK_W-1:0]      out_mask_r, out_mask_nxt;
  logic [dde_pkg::OUT_CNT_W-1:0]   out_count_r, out_count_nxt;

  logic [PW-1:0]                   pi;
  logic [dde_pkg::IDX_EXT_W-1:0]   pe;
  logic                            p_in_rng, fin_cur;
  logic                            exit_init, exit_chk, exit_last;

  assign pi        = p_r[PW-1:0];
  assign pe        = dde_pkg::IDX_EXT_W'(p_r);
  assign p_in_rng  = p_r < np;
  assign fin_cur   = fin_r[pi];
  assign exit_init = exit_tok.valid && (exit_tok.op == dde_pkg::OP_INIT);
  assign exit_chk  = exit_tok.valid && (exit_tok.op == dde_pkg::OP_CHECK);
  assign exit_last = CW'(exit_p) == (np - CW'(1));

  always_comb begin
    state_nxt        = state_r;
    p_nxt            = p_r;
    chg_nxt          = chg_r;
    fin_nxt          = fin_r;
    drn_nxt          = drn_r;
    cnt_nxt          = cnt_r;
    mask_nxt         = mask_r;
    out_valid_nxt    = out_valid_r;
    out_deadlock_nxt = out_deadlock_r;
    out_mask_nxt     = out_mask_r;
    out_count_nxt    = out_count_r;
    inj_tok.valid    = 1'b0;
    inj_tok.op       = dde_pkg::OP_INIT;
    inj_tok.flag     = 1'b1;
    inj_p            = pi;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    // processes with no allocation start finished
    if (exit_init) begin
      fin_nxt[exit_p] = exit_tok.flag;
    end

    unique case (state_r)
      S_IDLE: begin
        if (run_go) begin
          fin_nxt   = '0;
          p_nxt     = '0;
          chg_nxt   = 1'b0;
          drn_nxt   = '0;
          state_nxt = (np == '0) ? S_DRAIN : S_INIT;
        end
      end
      S_INIT: begin
        inj_tok.valid = 1'b1;
        p_nxt         = p_r + CW'(1);
        if (p_r == (np - CW'(1))) begin
          state_nxt = S_INIT_WAIT;
        end
      end
      S_INIT_WAIT: begin
        if (exit_init && exit_last) begin
          p_nxt     = '0;
          chg_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!p_in_rng) begin
          p_nxt = '0;
          if (chg_r) begin
            chg_nxt = 1'b0;
          end else begin
            drn_nxt   = '0;
            state_nxt = S_DRAIN;
          end
        end else if (fin_cur) begin
          p_nxt = p_r + CW'(1);
        end else begin
          inj_tok.valid = 1'b1;
          inj_tok.op    = dde_pkg::OP_CHECK;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (exit_chk) begin
          if (exit_tok.flag) begin
            // process finishes: hand its allocation back to work
            fin_nxt[pi]   = 1'b1;
            chg_nxt       = 1'b1;
            inj_tok.valid = 1'b1;
            inj_tok.op    = dde_pkg::OP_ADD;
          end
          p_nxt     = p_r + CW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_DRAIN: begin
        if (drn_r == DW'(DRAIN_LEN)) begin
          p_nxt     = '0;
          cnt_nxt   = '0;
          mask_nxt  = '0;
          state_nxt = S_COUNT;
        end else begin
          drn_nxt = drn_r + DW'(1);
        end
      end
      S_COUNT: begin
        if (!p_in_rng) begin
          state_nxt = S_DONE;
        end else begin
          if (!fin_cur) begin
            cnt_nxt = cnt_r + CW'(1);
            if (pe < dde_pkg::IDX_EXT_W'(dde_pkg::MASK_W)) begin
              mask_nxt[pe[dde_pkg::MASK_IW-1:0]] = 1'b1;
            end
          end
          p_nxt = p_r + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_deadlock_nxt = cnt_r != '0;
          out_mask_nxt     = mask_r;
          out_count_nxt    = dde_pkg::OUT_CNT_W'(cnt_r);
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      chg_r       <= 1'b0;
      fin_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chg_r       <= chg_nxt;
      fin_r       <= fin_nxt;
    end
    p_r            <= p_nxt;
    drn_r          <= drn_nxt;
    cnt_r          <= cnt_nxt;
    mask_r         <= mask_nxt;
    out_deadlock_r <= out_deadlock_nxt;
    out_mask_r     <= out_mask_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign busy         = state_r != S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_deadlock = out_deadlock_r;
  assign out_mask     = out_mask_r;
  assign out_count    = out_count_r;

  a_run_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    run_go |-> state_r == S_IDLE)
    else $error("run started while a run is in progress");

  a_exit_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    exit_tok.valid |-> (state_r != S_IDLE && state_r != S_COUNT && state_r != S_DONE))
    else $error("token left the chain after the drain");

  a_wait_adds_only : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && inj_tok.valid) |-> inj_tok.op == dde_pkg::OP_ADD)
    else $error("new check issued before the previous one resolved");

endmodule
